### rtl/srdb_pkg.sv
// srdb_pkg: shared types, constants and round functions for the salsa
// differential bias counter; used by salsa_round_differential_bias
`timescale 1ns / 1ps

package srdb_pkg;

  // round and counter sizing
  localparam int unsigned ROUND_COUNT = 4;
  localparam int unsigned STEPS_PER_ROUND = 4;
  localparam int unsigned NUM_STAGES = ROUND_COUNT * STEPS_PER_ROUND;
  localparam int unsigned COUNT_WIDTH = 48;
  localparam int unsigned TOTAL_WIDTH = 48;
  localparam int unsigned NUM_FREE = 12;
  localparam int unsigned IN_DATA_WIDTH = NUM_FREE * 32;
  localparam int unsigned OUT_DATA_WIDTH = 104;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] state_t;
  typedef logic [3:0] widx_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  // configuration register indexes
  localparam logic [2:0] CFG_FLIP_WORD    = 3'd0;
  localparam logic [2:0] CFG_FLIP_BIT     = 3'd1;
  localparam logic [2:0] CFG_CHECK_WORD_A = 3'd2;
  localparam logic [2:0] CFG_CHECK_BIT    = 3'd3;
  localparam logic [2:0] CFG_CHECK_WORD_B = 3'd4;
  localparam logic [2:0] CFG_CHECK_SHIFT  = 3'd5;

  // configuration reset values
  localparam logic [3:0] RST_FLIP_WORD    = 4'd7;
  localparam logic [4:0] RST_FLIP_BIT     = 5'd31;
  localparam logic [3:0] RST_CHECK_WORD_A = 4'd12;
  localparam logic [4:0] RST_CHECK_BIT    = 5'd0;
  localparam logic [3:0] RST_CHECK_WORD_B = 4'd4;
  localparam logic [4:0] RST_CHECK_SHIFT  = 5'd7;

  // diagonal constants
  localparam word_t SIGMA_0 = 32'h61707865;
  localparam word_t SIGMA_1 = 32'h3320646e;
  localparam word_t SIGMA_2 = 32'h79622d32;
  localparam word_t SIGMA_3 = 32'h6b206574;

  // state positions of the free words, in transfer order
  localparam widx_t FREE_POS [NUM_FREE] = '{
    4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd9, 4'd11, 4'd12, 4'd13, 4'd14
  };

  // quarter-round word groups
  localparam widx_t COL_SETS [4][4] = '{
    '{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd5, 4'd9, 4'd13, 4'd1},
    '{4'd10, 4'd14, 4'd2, 4'd6}, '{4'd15, 4'd3, 4'd7, 4'd11}
  };
  localparam widx_t ROW_SETS [4][4] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3}, '{4'd5, 4'd6, 4'd7, 4'd4},
    '{4'd10, 4'd11, 4'd8, 4'd9}, '{4'd15, 4'd12, 4'd13, 4'd14}
  };

  // rotate left by a fixed amount
  function automatic word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // one add-rotate-xor step of all four quarter rounds of a round
  function automatic state_t salsa_step(state_t s, logic is_row, int unsigned step);
    state_t r;
    widx_t p0, p1, p2, p3;
    r = s;
    for (int q = 0; q < 4; q++) begin
      p0 = is_row ? ROW_SETS[q][0] : COL_SETS[q][0];
      p1 = is_row ? ROW_SETS[q][1] : COL_SETS[q][1];
      p2 = is_row ? ROW_SETS[q][2] : COL_SETS[q][2];
      p3 = is_row ? ROW_SETS[q][3] : COL_SETS[q][3];
      case (step)
        0: r[p1] = s[p1] ^ rotl(s[p3] + s[p0], 7);
        1: r[p2] = s[p2] ^ rotl(s[p0] + s[p1], 9);
        2: r[p3] = s[p3] ^ rotl(s[p1] + s[p2], 13);
        3: r[p0] = s[p0] ^ rotl(s[p2] + s[p3], 18);
        default: r[p0] = s[p0];
      endcase
    end
    return r;
  endfunction

endpackage

### rtl/salsa_round_differential_bias.sv
// salsa_round_differential_bias: top level, pipelined pair of salsa round
// evaluations with differential check bit and saturating trial counters
// depends on srdb_pkg
`timescale 1ns / 1ps

// Takes one trial per cycle: each transfer brings the twelve free words of a
// salsa state, the block builds the state and a copy with the configured bit
// flipped, and runs both through a pipeline of ROUND_COUNT * 4 stages, one
// add-rotate-xor step of all four quarter rounds per stage. A result passes
// from its input transfer through the input register, then the round stages
// and the result register to the result port; throughput is one trial per
// cycle, and the whole pipeline holds while a result waits on
// m_axis_tready_i. The result carries the check bit outcome and both
// running counters, which saturate at all ones.
// Configuration writes are meant for an idle block.
module salsa_round_differential_bias
  import srdb_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write port
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_idx_i,
  input  logic [4:0]                cfg_wdata_i,
  // input stream
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // free_word_1, 2, 3, 4, 6, 7, 8, 9, 11, 12, 13, 14 (32 bits each)
  input  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata_i,
  // result stream
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // bit_is_zero (1), zero_total (48), trial_total (48), zero padding (7)
  output logic [OUT_DATA_WIDTH-1:0] m_axis_tdata_o
);

  // configuration registers
  logic [3:0] flip_word_q, check_word_a_q, check_word_b_q;
  logic [4:0] flip_bit_q, check_bit_q, check_shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flip_word_q    <= RST_FLIP_WORD;
      flip_bit_q     <= RST_FLIP_BIT;
      check_word_a_q <= RST_CHECK_WORD_A;
      check_bit_q    <= RST_CHECK_BIT;
      check_word_b_q <= RST_CHECK_WORD_B;
      check_shift_q  <= RST_CHECK_SHIFT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FLIP_WORD:    flip_word_q    <= cfg_wdata_i[3:0];
        CFG_FLIP_BIT:     flip_bit_q     <= cfg_wdata_i;
        CFG_CHECK_WORD_A: check_word_a_q <= cfg_wdata_i[3:0];
        CFG_CHECK_BIT:    check_bit_q    <= cfg_wdata_i;
        CFG_CHECK_WORD_B: check_word_b_q <= cfg_wdata_i[3:0];
        CFG_CHECK_SHIFT:  check_shift_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline advance: everything moves unless a result is stuck
  logic out_valid_q;
  logic adv;
  assign adv = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // build the base state and the flipped copy
  state_t base_st, flip_st;
  always_comb begin
    base_st = '0;
    for (int i = 0; i < NUM_FREE; i++) begin
      base_st[FREE_POS[i]] = s_axis_tdata_i[i*32 +: 32];
    end
    base_st[0]  = SIGMA_0;
    base_st[5]  = SIGMA_1;
    base_st[10] = SIGMA_2;
    base_st[15] = SIGMA_3;
    flip_st = base_st;
    flip_st[flip_word_q] = base_st[flip_word_q] ^ (32'd1 << flip_bit_q);
  end

  // stage 0 is the input register, the last stage holds the finished rounds
  state_t                st0_q [NUM_STAGES+1];
  state_t                st1_q [NUM_STAGES+1];
  logic [NUM_STAGES:0]   vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NUM_STAGES-1:0], s_axis_tvalid_i};
    end
  end

  // round step stages: column round first, then alternating with row rounds
  always_ff @(posedge clk_i) begin
    if (adv) begin
      st0_q[0] <= base_st;
      st1_q[0] <= flip_st;
      for (int k = 0; k < NUM_STAGES; k++) begin
        st0_q[k+1] <= salsa_step(st0_q[k], ((k / STEPS_PER_ROUND) % 2) == 1,
                                 k % STEPS_PER_ROUND);
        st1_q[k+1] <= salsa_step(st1_q[k], ((k / STEPS_PER_ROUND) % 2) == 1,
                                 k % STEPS_PER_ROUND);
      end
    end
  end

  // check bit from the two examined differences
  word_t      diff_a, diff_b;
  logic [5:0] pos;
  logic       chk_bit;
  always_comb begin
    diff_a  = st0_q[NUM_STAGES][check_word_a_q] ^ st1_q[NUM_STAGES][check_word_a_q];
    diff_b  = st0_q[NUM_STAGES][check_word_b_q] ^ st1_q[NUM_STAGES][check_word_b_q];
    pos     = {1'b0, check_bit_q} + {1'b0, check_shift_q};
    chk_bit = diff_a[check_bit_q] ^ (pos[5] ? 1'b0 : diff_b[pos[4:0]]);
  end

  // saturating counters and result register
  count_t zero_cnt_q, trial_cnt_q;
  count_t zero_cnt_d, trial_cnt_d;
  logic   bit_zero_q;
  logic   load_out;

  assign load_out = adv && vld_q[NUM_STAGES];

  always_comb begin
    trial_cnt_d = (&trial_cnt_q) ? trial_cnt_q : trial_cnt_q + COUNT_WIDTH'(1);
    zero_cnt_d  = zero_cnt_q;
    if (!chk_bit && !(&zero_cnt_q)) begin
      zero_cnt_d = zero_cnt_q + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      zero_cnt_q  <= '0;
      trial_cnt_q <= '0;
    end else if (adv) begin
      out_valid_q <= vld_q[NUM_STAGES];
      if (load_out) begin
        zero_cnt_q  <= zero_cnt_d;
        trial_cnt_q <= trial_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      bit_zero_q <= ~chk_bit;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {
    (OUT_DATA_WIDTH - 1 - 2 * TOTAL_WIDTH)'(0),
    TOTAL_WIDTH'(trial_cnt_q),
    TOTAL_WIDTH'(zero_cnt_q),
    bit_zero_q
  };

`ifndef NO_ASSERTIONS
  // zero count never passes the trial count
  assert property (@(posedge clk_i) disable iff (!rst_ni) zero_cnt_q <= trial_cnt_q)
    else $error("zero counter exceeds trial counter");

  // trial counter steps by one per finished trial until saturated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (trial_cnt_q == $past(trial_cnt_q) + COUNT_WIDTH'(1)) || (&trial_cnt_q))
    else $error("trial counter missed an increment");

  // counters only move when a trial enters the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_out |=> $stable(trial_cnt_q) && $stable(zero_cnt_q))
    else $error("counter changed without a trial");

  // a pending result always has at least one trial behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_q |-> trial_cnt_q != '0)
    else $error("result pending with empty trial counter");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for salsa_round_differential_bias; predicts the check bit
// and both running tallies of every trial and compares each result transfer
// depends on srdb_pkg and rtl/salsa_round_differential_bias.sv

module tb_top;
  import srdb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = NUM_STAGES + 6;
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_LEN     = 300;
  localparam int unsigned MAX_REPORTS  = 40;
  // indexes past the register list, writes there must be ignored
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [3:0] flip_word;
    logic [4:0] flip_bit;
    logic [3:0] word_a;
    logic [4:0] bit_a;
    logic [3:0] word_b;
    logic [4:0] shift_b;
  } probe_cfg_t;

  typedef struct packed {
    logic   zero;
    count_t zeros;
    count_t trials;
  } tally_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [2:0]                cfg_idx_i = '0;
  logic [4:0]                cfg_wdata_i = '0;
  logic                      s_axis_tvalid_i = 1'b0;
  logic                      s_axis_tready_o;
  // free_word_1, 2, 3, 4, 6, 7, 8, 9, 11, 12, 13, 14 (32 bits each)
  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata_i = '0;
  logic                      m_axis_tvalid_o;
  logic                      m_axis_tready_i = 1'b0;
  // bit_is_zero (1), zero_total (48), trial_total (48), zero padding (7)
  logic [OUT_DATA_WIDTH-1:0] m_axis_tdata_o;

  logic [IN_DATA_WIDTH-1:0] trial_queue [$];
  tally_t                   expected_tallies [$];
  probe_cfg_t               cfg_now;
  count_t                   zero_tally = '0;
  count_t                   trial_tally = '0;

  int unsigned sent_count = 0;
  int unsigned result_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  logic        offer_free;
  logic        next_valid;
  logic        ready_next;

  salsa_round_differential_bias dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // rotate left through a doubled word
  function automatic word_t rol32(word_t v, int unsigned n);
    logic [63:0] d;
    d = {v, v} << n;
    return d[63:32];
  endfunction

  // add-rotate-xor on one group of four words
  function automatic state_t quarter_mix(state_t s, int a, int b, int c, int d);
    s[b] = s[b] ^ rol32(s[d] + s[a], 7);
    s[c] = s[c] ^ rol32(s[a] + s[b], 9);
    s[d] = s[d] ^ rol32(s[b] + s[c], 13);
    s[a] = s[a] ^ rol32(s[c] + s[d], 18);
    return s;
  endfunction

  // column round first, then alternate with row rounds
  function automatic state_t scramble(state_t s);
    for (int r = 0; r < ROUND_COUNT; r++) begin
      if (r % 2 == 0) begin
        s = quarter_mix(s, 0, 4, 8, 12);
        s = quarter_mix(s, 5, 9, 13, 1);
        s = quarter_mix(s, 10, 14, 2, 6);
        s = quarter_mix(s, 15, 3, 7, 11);
      end else begin
        s = quarter_mix(s, 0, 1, 2, 3);
        s = quarter_mix(s, 5, 6, 7, 4);
        s = quarter_mix(s, 10, 11, 8, 9);
        s = quarter_mix(s, 15, 12, 13, 14);
      end
    end
    return s;
  endfunction

  // 1 when the combined difference bit of one trial is zero
  function automatic logic trial_bit_zero(logic [IN_DATA_WIDTH-1:0] words, probe_cfg_t c);
    state_t      plain;
    state_t      flipped;
    word_t       da;
    word_t       db;
    logic        bit_v;
    int unsigned pos;
    plain = '0;
    // free words fill slots 1-4, 6-9 and 11-14
    for (int i = 0; i < NUM_FREE; i++)
      plain[i + 1 + i / 4] = words[32 * i +: 32];
    plain[0]  = SIGMA_0;
    plain[5]  = SIGMA_1;
    plain[10] = SIGMA_2;
    plain[15] = SIGMA_3;
    flipped = plain;
    flipped[c.flip_word][c.flip_bit] = ~flipped[c.flip_word][c.flip_bit];
    plain   = scramble(plain);
    flipped = scramble(flipped);
    da = plain[c.word_a] ^ flipped[c.word_a];
    db = plain[c.word_b] ^ flipped[c.word_b];
    bit_v = da[c.bit_a];
    pos = c.bit_a + c.shift_b;
    // second term drops out past bit 31
    if (pos < 32) bit_v = bit_v ^ db[pos];
    return ~bit_v;
  endfunction

  // predict one accepted trial and queue its result
  task automatic record_trial(input logic [IN_DATA_WIDTH-1:0] words);
    tally_t t;
    t.zero = trial_bit_zero(words, cfg_now);
    if (trial_tally != '1) trial_tally = trial_tally + 1'b1;
    if (t.zero && zero_tally != '1) zero_tally = zero_tally + 1'b1;
    t.zeros  = zero_tally;
    t.trials = trial_tally;
    expected_tallies.push_back(t);
  endtask

  task automatic note_mismatch(input string what, input count_t want, input count_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
  endtask

  // compare one result transfer with the oldest prediction
  task automatic check_result(input logic [OUT_DATA_WIDTH-1:0] data);
    tally_t want;
    if (expected_tallies.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: unexpected result, expected none actual %h", $time, data);
    end else begin
      want = expected_tallies.pop_front();
      if (data[0] !== want.zero) note_mismatch("bit_is_zero", want.zero, data[0]);
      if (data[48:1] !== want.zeros) note_mismatch("zero_total", want.zeros, data[48:1]);
      if (data[96:49] !== want.trials) note_mismatch("trial_total", want.trials, data[96:49]);
    end
  endtask

  // mostly short gaps, now and then a long one
  function automatic int unsigned draw_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [4:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FLIP_WORD:    cfg_now.flip_word = val[3:0];
      CFG_FLIP_BIT:     cfg_now.flip_bit  = val;
      CFG_CHECK_WORD_A: cfg_now.word_a    = val[3:0];
      CFG_CHECK_BIT:    cfg_now.bit_a     = val;
      CFG_CHECK_WORD_B: cfg_now.word_b    = val[3:0];
      CFG_CHECK_SHIFT:  cfg_now.shift_b   = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [4:0] fw, input logic [4:0] fb,
                               input logic [4:0] wa, input logic [4:0] ba,
                               input logic [4:0] wb, input logic [4:0] sb);
    write_reg(CFG_FLIP_WORD, fw);
    write_reg(CFG_FLIP_BIT, fb);
    write_reg(CFG_CHECK_WORD_A, wa);
    write_reg(CFG_CHECK_BIT, ba);
    write_reg(CFG_CHECK_WORD_B, wb);
    write_reg(CFG_CHECK_SHIFT, sb);
  endtask

  // random trials, words now and then at their extremes
  task automatic queue_random(input int unsigned n);
    logic [IN_DATA_WIDTH-1:0] item;
    int unsigned              pick;
    @(negedge clk_i);
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < NUM_FREE; i++) begin
        pick = $urandom_range(0, 15);
        item[32 * i +: 32] = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFFFFFF : $urandom;
      end
      trial_queue.push_back(item);
    end
  endtask

  // block drained and pipeline flushed, sampled away from the active edge
  task automatic wait_idle();
    while (trial_queue.size() != 0 || s_axis_tvalid_i || expected_tallies.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // input driver: one transfer per handshake, random gaps between items
  always @(posedge clk_i) begin
    if (rst_ni) begin
      offer_free = !s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        record_trial(s_axis_tdata_i);
        sent_count++;
        offer_free = 1'b1;
      end
      if (offer_free) begin
        next_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (trial_queue.size() > 0) begin
          next_valid = 1'b1;
          s_axis_tdata_i <= trial_queue.pop_front();
          send_gap = ((sent_count / 50) % 3 == 2) ? 0 : draw_gap();
        end
        s_axis_tvalid_i <= next_valid;
      end
    end
  end

  // result monitor with random stalls and one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        check_result(m_axis_tdata_o);
        result_count++;
        if (result_count == HOLD_AT) hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        stall_left = ((result_count / 70) % 3 == 1) ? 0 : draw_gap();
        ready_next = (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
      m_axis_tready_i <= ready_next;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // stimulus phases
  initial begin
    logic [IN_DATA_WIDTH-1:0] item;
    cfg_now = '{flip_word: RST_FLIP_WORD, flip_bit: RST_FLIP_BIT,
                word_a: RST_CHECK_WORD_A, bit_a: RST_CHECK_BIT,
                word_b: RST_CHECK_WORD_B, shift_b: RST_CHECK_SHIFT};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting, directed word patterns
    @(negedge clk_i);
    trial_queue.push_back('0);
    trial_queue.push_back('1);
    trial_queue.push_back({NUM_FREE{32'hAAAAAAAA}});
    trial_queue.push_back({NUM_FREE{32'h55555555}});
    trial_queue.push_back({NUM_FREE{32'h80000000}});
    trial_queue.push_back({NUM_FREE{32'h00000001}});
    for (int i = 0; i < NUM_FREE; i++) begin
      item = '0;
      item[32 * i +: 32] = 32'hFFFFFFFF;
      trial_queue.push_back(item);
    end
    item = '0;
    for (int i = 0; i < NUM_FREE; i++) item[32 * i +: 32] = 32'h1 << (i * 2 + 7);
    trial_queue.push_back(item);
    trial_queue.push_back(~item);
    wait_idle();

    // flip in constant word 0, same word and same bit checked twice
    apply_setting(5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
    queue_random(100);
    wait_idle();

    // all registers at their top values, shifted position past bit 31
    apply_setting(5'd15, 5'd31, 5'd15, 5'd31, 5'd15, 5'd31);
    queue_random(100);
    wait_idle();

    // flip in constant word 5, shifted position exactly at bit 31
    apply_setting(5'd5, 5'd16, 5'd3, 5'd1, 5'd9, 5'd30);
    queue_random(100);
    wait_idle();

    // word indexes masked to four bits, writes past the list ignored
    apply_setting(5'd26, 5'd7, 5'd31, 5'd5, 5'd16, 5'd4);
    write_reg(CFG_SPARE_LO, 5'd3);
    write_reg(CFG_SPARE_HI, 5'd31);
    queue_random(300);
    wait_idle();

    // random settings
    for (int p = 0; p < 3; p++) begin
      apply_setting($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
      queue_random(85);
      wait_idle();
    end

    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
rtl/srdb_pkg.sv
rtl/salsa_round_differential_bias.sv
tb/tb_top.sv
